@@ hw/rtl/cwhi_pkg.sv @@
// ============================================================================
// cwhi_pkg
// Shared types and constants of the column wind height interpolator.
// ============================================================================
`default_nettype none

package cwhi_pkg;

   // fixed-point format of heights and velocities
   localparam int DATA_W    = 32;
   localparam int REF_W     = 31;
   localparam int FRAC_BITS = 16;

   // reset value of the reference height: 10.0 m in Q16.16
   localparam logic [REF_W-1:0] REF_HEIGHT_RESET = REF_W'(655360);

   // weight runs from 0 to 1.0 inclusive
   localparam int W_W = FRAC_BITS + 1;
   localparam logic [W_W-1:0] WEIGHT_ONE = W_W'(1) << FRAC_BITS;

   // divider step counter
   localparam int CNT_W = $clog2(FRAC_BITS);

   // signed difference (33 bits) times signed weight (W_W + 1 bits)
   localparam int DIFF_W = DATA_W + 1;
   localparam int PROD_W = DIFF_W + W_W + 1;

   // column queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic              short_col;
      logic [DATA_W-1:0] target;
      logic [DATA_W-1:0] lo_h;
      logic [DATA_W-1:0] up_h;
      logic [DATA_W-1:0] lo_u;
      logic [DATA_W-1:0] up_u;
      logic [DATA_W-1:0] lo_v;
      logic [DATA_W-1:0] up_v;
   } queue_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SETUP,
      BK_DIVIDE,
      BK_MUL_U,
      BK_MUL_V,
      BK_DONE
   } back_state_type;

endpackage

`default_nettype wire

@@ hw/rtl/cwhi_if.sv @@
// ============================================================================
// cwhi_if
// Valid/ready channels: column levels in, interpolated winds out.
// ============================================================================
`default_nettype none

interface cwhi_req_if;
   import cwhi_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] level_height;
   logic [DATA_W-1:0] u_west_face;
   logic [DATA_W-1:0] u_east_face;
   logic [DATA_W-1:0] v_south_face;
   logic [DATA_W-1:0] v_north_face;
   logic              last_level;

   modport source (
      output valid, level_height, u_west_face, u_east_face,
             v_south_face, v_north_face, last_level,
      input  ready
   );

   modport sink (
      input  valid, level_height, u_west_face, u_east_face,
             v_south_face, v_north_face, last_level,
      output ready
   );
endinterface

interface cwhi_rsp_if;
   import cwhi_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] u_at_reference;
   logic [DATA_W-1:0] v_at_reference;
   logic              short_column;

   modport source (
      output valid, u_at_reference, v_at_reference, short_column,
      input  ready
   );

   modport sink (
      input  valid, u_at_reference, v_at_reference, short_column,
      output ready
   );
endinterface

`default_nettype wire

@@ hw/rtl/column_wind_height_interpolator_unit.sv @@
// ============================================================================
// column_wind_height_interpolator_unit
// Interpolates face-averaged column winds to a reference height.
// ============================================================================
// Levels arrive bottom first, one word per level, and a word with last_level
// set closes the column and produces exactly one result word. The front
// takes one level per cycle whenever the column queue has room: it averages
// the face velocities, forms the target (first height plus reference_height,
// saturated) and latches the first level pair that brackets the target, or
// the top pair. Each closed column goes into a two-entry queue. The back
// takes one column at a time: a setup state classifies the weight, a
// restoring divider produces one weight bit a cycle (FRAC_BITS bits, only
// when the weight is strictly between 0 and 1), then the u and v products
// share one multiplier in turn, and a done state loads the output register
// once the register is free. A single-level column skips the divider and the
// multiplier. Heights and winds are Q16.16. Levels stream at one level a
// cycle while the back keeps pace; otherwise the full queue holds the front.
// The output register holds a finished word while the back works on the
// next column. Write reference_height only while no column is in flight.
// ============================================================================
`default_nettype none

module column_wind_height_interpolator_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_en,
   input  logic [cwhi_pkg::REF_W-1:0]  csr_write_data,
   cwhi_req_if.sink                    req_chan,
   cwhi_rsp_if.source                  rsp_chan
);
   import cwhi_pkg::*;

   // front -> queue
   logic            q_push;
   queue_entry_type q_entry;

   // queue <-> back
   qstat_type       qstat;
   queue_entry_type q_head;
   logic            q_pop;

   // accept levels, track the bracket, push closed columns
   cwhi_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_chan       (req_chan),
      .qstat          (qstat),
      .q_push         (q_push),
      .q_entry        (q_entry)
   );

   // hold closed columns until the back is free
   cwhi_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_entry (q_entry),
      .q_pop   (q_pop),
      .qstat   (qstat),
      .q_head  (q_head)
   );

   // divide, interpolate, drive the result word
   cwhi_back u_back (
      .clock    (clock),
      .reset    (reset),
      .qstat    (qstat),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

@@ hw/rtl/cwhi_front.sv @@
// ============================================================================
// cwhi_front
// Level intake: target height, centre velocities and bracket tracking.
// ============================================================================
`default_nettype none

module cwhi_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [cwhi_pkg::REF_W-1:0]        csr_write_data,
   cwhi_req_if.sink                          req_chan,
   input  cwhi_pkg::qstat_type               qstat,
   output logic                              q_push,
   output cwhi_pkg::queue_entry_type         q_entry
);
   import cwhi_pkg::*;

   logic [REF_W-1:0]  ref_ff;
   logic              at_start_ff, at_start_in;
   logic              found_ff, found_in;
   logic [DATA_W-1:0] target_ff, target_in;
   logic [DATA_W-1:0] prev_h_ff, prev_u_ff, prev_v_ff;
   logic [DATA_W-1:0] lo_h_ff, up_h_ff, lo_u_ff, up_u_ff, lo_v_ff, up_v_ff;

   logic              accept;
   logic [DATA_W:0]   sum_u, sum_v, sum_t;
   logic [DATA_W-1:0] uc, vc, tgt_new;
   logic              take;
   logic [DATA_W-1:0] sel_lo_h, sel_up_h, sel_lo_u, sel_up_u, sel_lo_v, sel_up_v;

   assign req_chan.ready = !qstat.full;
   assign accept         = req_chan.valid && req_chan.ready;

   // exact 33-bit sums, then floor halving
   assign sum_u = {req_chan.u_west_face[DATA_W-1], req_chan.u_west_face}
                + {req_chan.u_east_face[DATA_W-1], req_chan.u_east_face};
   assign sum_v = {req_chan.v_south_face[DATA_W-1], req_chan.v_south_face}
                + {req_chan.v_north_face[DATA_W-1], req_chan.v_north_face};
   assign uc = sum_u[DATA_W:1];
   assign vc = sum_v[DATA_W:1];

   // target = height + reference, saturated high (reference is never negative)
   assign sum_t = {req_chan.level_height[DATA_W-1], req_chan.level_height}
                + {2'b00, ref_ff};
   always_comb begin
      if (!sum_t[DATA_W] && sum_t[DATA_W-1]) begin
         tgt_new = {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
         tgt_new = sum_t[DATA_W-1:0];
      end
   end

   // first pair with previous <= target < current, else the top pair
   assign take = !found_ff &&
                 (($signed(prev_h_ff) <= $signed(target_ff) &&
                   $signed(target_ff) < $signed(req_chan.level_height)) ||
                  req_chan.last_level);

   assign sel_lo_h = take ? prev_h_ff              : lo_h_ff;
   assign sel_up_h = take ? req_chan.level_height  : up_h_ff;
   assign sel_lo_u = take ? prev_u_ff              : lo_u_ff;
   assign sel_up_u = take ? uc                     : up_u_ff;
   assign sel_lo_v = take ? prev_v_ff              : lo_v_ff;
   assign sel_up_v = take ? vc                     : up_v_ff;

   always_comb begin
      at_start_in = at_start_ff;
      found_in    = found_ff;
      target_in   = target_ff;
      if (accept) begin
         if (at_start_ff) begin
            target_in   = tgt_new;
            at_start_in = req_chan.last_level;
            found_in    = 1'b0;
         end else begin
            at_start_in = req_chan.last_level;
            found_in    = req_chan.last_level ? 1'b0 : (found_ff || take);
         end
      end
   end

   assign q_push = accept && req_chan.last_level;

   always_comb begin
      q_entry.short_col = at_start_ff;
      q_entry.target    = target_ff;
      q_entry.lo_h      = sel_lo_h;
      q_entry.up_h      = sel_up_h;
      q_entry.lo_u      = sel_lo_u;
      q_entry.up_u      = sel_up_u;
      q_entry.lo_v      = sel_lo_v;
      q_entry.up_v      = sel_up_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff      <= REF_HEIGHT_RESET;
         at_start_ff <= 1'b1;
         found_ff    <= 1'b0;
      end else begin
         if (csr_write_en) begin
            ref_ff <= csr_write_data;
         end
         at_start_ff <= at_start_in;
         found_ff    <= found_in;
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      target_ff <= target_in;
      if (accept) begin
         prev_h_ff <= req_chan.level_height;
         prev_u_ff <= uc;
         prev_v_ff <= vc;
         if (!at_start_ff && take) begin
            lo_h_ff <= sel_lo_h;
            up_h_ff <= sel_up_h;
            lo_u_ff <= sel_lo_u;
            up_u_ff <= sel_up_u;
            lo_v_ff <= sel_lo_v;
            up_v_ff <= sel_up_v;
         end
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/cwhi_queue.sv @@
// ============================================================================
// cwhi_queue
// Short FIFO of finished columns between intake and interpolation.
// ============================================================================
`default_nettype none

module cwhi_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_push,
   input  cwhi_pkg::queue_entry_type     q_entry,
   input  logic                          q_pop,
   output cwhi_pkg::qstat_type           qstat,
   output cwhi_pkg::queue_entry_type     q_head
);
   import cwhi_pkg::*;

   queue_entry_type   mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic              do_push, do_pop;

   assign qstat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign do_push     = q_push && !qstat.full;
   assign do_pop      = q_pop && !qstat.empty;
   assign q_head      = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= q_entry;
      end
   end

`ifndef SYNTH
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !qstat.full)
      else $error("column pushed into a full queue");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/cwhi_back.sv @@
// ============================================================================
// cwhi_back
// Per-column weight division, two interpolation multiplies, output word.
// ============================================================================
`default_nettype none

module cwhi_back (
   input  logic                          clock,
   input  logic                          reset,
   input  cwhi_pkg::qstat_type           qstat,
   input  cwhi_pkg::queue_entry_type     q_head,
   output logic                          q_pop,
   cwhi_rsp_if.source                    rsp_chan
);
   import cwhi_pkg::*;

   back_state_type    state_ff, state_in;
   queue_entry_type   job_ff;
   logic [DATA_W-1:0] rem_ff, den_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [W_W-1:0]    w_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [DATA_W-1:0] u_res_ff;
   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_u_ff, rsp_v_ff;
   logic              rsp_short_ff;

   logic signed [DIFF_W-1:0] num, den, diff_u, diff_v, mult_b;
   logic              num_pos, den_pos, num_ge;
   logic [DATA_W:0]   rem_shift;
   logic              rem_fits;
   logic [DATA_W-1:0] v_res;
   logic              out_free, load_out;

   assign num = $signed({job_ff.target[DATA_W-1], job_ff.target})
              - $signed({job_ff.lo_h[DATA_W-1], job_ff.lo_h});
   assign den = $signed({job_ff.up_h[DATA_W-1], job_ff.up_h})
              - $signed({job_ff.lo_h[DATA_W-1], job_ff.lo_h});
   assign num_pos = !num[DIFF_W-1] && (num != '0);
   assign den_pos = !den[DIFF_W-1] && (den != '0);
   assign num_ge  = (num >= den);

   // restoring division, one quotient bit a cycle
   assign rem_shift = {rem_ff, 1'b0};
   assign rem_fits  = (rem_shift >= {1'b0, den_ff});

   assign diff_u = $signed({job_ff.up_u[DATA_W-1], job_ff.up_u})
                 - $signed({job_ff.lo_u[DATA_W-1], job_ff.lo_u});
   assign diff_v = $signed({job_ff.up_v[DATA_W-1], job_ff.up_v})
                 - $signed({job_ff.lo_v[DATA_W-1], job_ff.lo_v});
   assign mult_b  = (state_ff == BK_MUL_U) ? diff_u : diff_v;
   assign prod_in = $signed(PROD_W'(mult_b)) * $signed(PROD_W'({1'b0, w_ff}));

   assign v_res    = job_ff.lo_v + prod_ff[FRAC_BITS +: DATA_W];
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!qstat.empty) begin
               state_in = BK_SETUP;
            end
         end
         BK_SETUP: begin
            if (job_ff.short_col) begin
               state_in = BK_DONE;
            end else if (!den_pos || !num_pos || num_ge) begin
               state_in = BK_MUL_U;
            end else begin
               state_in = BK_DIVIDE;
            end
         end
         BK_DIVIDE: begin
            if (count_ff == '0) begin
               state_in = BK_MUL_U;
            end
         end
         BK_MUL_U: state_in = BK_MUL_V;
         BK_MUL_V: state_in = BK_DONE;
         BK_DONE: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_pop    = 1'b0;
      load_out = 1'b0;
      case (state_ff)
         BK_IDLE: q_pop    = !qstat.empty;
         BK_DONE: load_out = out_free;
         default: begin
            q_pop    = 1'b0;
            load_out = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         job_ff <= q_head;
      end
      case (state_ff)
         BK_SETUP: begin
            rem_ff   <= num[DATA_W-1:0];
            den_ff   <= den[DATA_W-1:0];
            count_ff <= CNT_W'(FRAC_BITS - 1);
            if (!den_pos || !num_pos) begin
               w_ff <= '0;
            end else if (num_ge) begin
               w_ff <= WEIGHT_ONE;
            end else begin
               w_ff <= '0;
            end
         end
         BK_DIVIDE: begin
            count_ff <= count_ff - 1'b1;
            w_ff     <= {w_ff[W_W-2:0], rem_fits};
            if (rem_fits) begin
               rem_ff <= DATA_W'(rem_shift - {1'b0, den_ff});
            end else begin
               rem_ff <= rem_shift[DATA_W-1:0];
            end
         end
         BK_MUL_U: prod_ff <= prod_in;
         BK_MUL_V: begin
            u_res_ff <= job_ff.lo_u + prod_ff[FRAC_BITS +: DATA_W];
            prod_ff  <= prod_in;
         end
         default: begin
         end
      endcase
      if (load_out) begin
         rsp_short_ff <= job_ff.short_col;
         rsp_u_ff     <= job_ff.short_col ? '0 : u_res_ff;
         rsp_v_ff     <= job_ff.short_col ? '0 : v_res;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.u_at_reference = rsp_u_ff;
   assign rsp_chan.v_at_reference = rsp_v_ff;
   assign rsp_chan.short_column   = rsp_short_ff;

`ifndef SYNTH
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DIVIDE) |-> (rem_ff < den_ff))
      else $error("divider remainder not below divisor");

   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_MUL_U) |-> (w_ff <= WEIGHT_ONE))
      else $error("interpolation weight above one");

   a_short_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_short_ff) |-> (rsp_u_ff == '0 && rsp_v_ff == '0))
      else $error("single-level column with nonzero wind");
`endif

endmodule

`default_nettype wire
